@@ rtl/m2m_pkg.sv @@
// ----------------------------------------------------------------------------
// m2m_pkg: shared types and constants for the MUS to MIDI event translator
// Parser phases, MUS event kinds, MIDI status kinds and the controller map.
// ----------------------------------------------------------------------------
package m2m_pkg;

	// Parser phase, one-hot coded.
	typedef enum logic [4:0] {
		PH_EVENT    = 5'b00001,
		PH_FIRST    = 5'b00010,
		PH_VELOCITY = 5'b00100,
		PH_VALUE    = 5'b01000,
		PH_DELAY    = 5'b10000
	} phase_t;

	// MUS event kinds, taken from bits 6..4 of the event byte.
	localparam logic [2:0] KIND_RELEASE    = 3'd0;
	localparam logic [2:0] KIND_PLAY       = 3'd1;
	localparam logic [2:0] KIND_BEND       = 3'd2;
	localparam logic [2:0] KIND_SYSTEM     = 3'd3;
	localparam logic [2:0] KIND_CONTROLLER = 3'd4;
	localparam logic [2:0] KIND_SCORE_END  = 3'd6;

	// MIDI status kinds, placed in the high nibble of the status byte.
	localparam logic [3:0] ST_NOTE_ON = 4'h9;
	localparam logic [3:0] ST_CTRL    = 4'hB;
	localparam logic [3:0] ST_PROGRAM = 4'hC;
	localparam logic [3:0] ST_BEND    = 4'hE;

	// Register indexes of the configuration port.
	localparam logic REG_CHANNEL_COUNT = 1'b0;

	// Miscellaneous constants.
	localparam logic [7:0] VEL_RESET      = 8'd100;
	localparam logic [7:0] CTRL_VOLUME    = 8'd7;
	localparam logic [7:0] DATA_MAX       = 8'h7F;
	localparam logic [7:0] SYS_MONO_MODE  = 8'd12;
	localparam logic [7:0] CTRL_PROGRAM   = 8'd0;

	// MUS channel to MIDI channel: 15 becomes the percussion channel 9,
	// 9 to 14 move up by one, the rest stay.
	function automatic logic [3:0] midi_channel(input logic [3:0] mus_ch);
		logic [3:0] ch;
		if (mus_ch == 4'd15) begin
			ch = 4'd9;
		end else if (mus_ch >= 4'd9) begin
			ch = mus_ch + 4'd1;
		end else begin
			ch = mus_ch;
		end
		return ch;
	endfunction

	// MUS controller index to MIDI controller number; out-of-range maps to 0.
	function automatic logic [7:0] controller_of(input logic [7:0] idx);
		logic [7:0] ctl;
		case (idx)
			8'd0:    ctl = 8'd0;
			8'd1:    ctl = 8'd0;
			8'd2:    ctl = 8'd1;
			8'd3:    ctl = 8'd7;
			8'd4:    ctl = 8'd10;
			8'd5:    ctl = 8'd11;
			8'd6:    ctl = 8'd91;
			8'd7:    ctl = 8'd93;
			8'd8:    ctl = 8'd64;
			8'd9:    ctl = 8'd67;
			8'd10:   ctl = 8'd120;
			8'd11:   ctl = 8'd123;
			8'd12:   ctl = 8'd126;
			8'd13:   ctl = 8'd127;
			8'd14:   ctl = 8'd121;
			default: ctl = 8'd0;
		endcase
		return ctl;
	endfunction

endpackage

@@ rtl/mus_to_midi_event_translator.sv @@
// ----------------------------------------------------------------------------
// mus_to_midi_event_translator: MUS score bytes in, MIDI channel events out
// Parses the MUS score body byte by byte and emits one MIDI event per
// completed MUS event, together with the delay that preceded it.
// ----------------------------------------------------------------------------
// The block takes one score byte per cycle and produces at most one event
// per byte; a byte is decoded in the cycle it is accepted and its event
// appears on the output register in the next cycle, so a new byte can be
// accepted every cycle as long as the output beat is taken (or the output
// register is empty). The rate is set by the single output register: the
// input stalls only while an event waits there and the consumer holds
// m_tready low. After the score end event (or an undefined event kind) all
// further bytes are accepted and dropped until reset. The user must write
// channel_count via APB address 0 only while the stream is idle (unchecked).
module mus_to_midi_event_translator
	import m2m_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Score byte input.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] score_byte
	// MIDI event output.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [31:0] delta_ticks, [39:32] midi_status,
	                               // [47:40] midi_data_one, [55:48] midi_data_two
	output logic        m_tlast,   // score_end
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Parser state.
	phase_t      phase_q, phase_d;
	logic [7:0]  event_q, event_d;
	logic [7:0]  first_q, first_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] pend_q, pend_d;
	logic        finished_q, finished_d;
	logic [7:0]  vel_q [16];
	logic [3:0]  channel_count_q;

	// Output register.
	logic        m_tvalid_q;
	logic [55:0] m_tdata_q;
	logic        m_tlast_q;

	// Decode results for the current byte.
	logic        in_beat;
	logic [7:0]  b;
	logic [3:0]  ch;
	logic [2:0]  kind;
	logic        do_emit;
	logic        do_finish;
	logic        vel_we;
	logic        res_vld;
	logic        res_end;
	logic [31:0] res_delta;
	logic [7:0]  res_status;
	logic [7:0]  res_d1;
	logic [7:0]  res_d2;
	logic [7:0]  ctl;
	logic        reg_sel;

	assign b       = s_tdata;
	assign ch      = midi_channel(event_q[3:0]);
	assign kind    = event_q[6:4];
	assign ctl     = controller_of(first_q);
	assign in_beat = s_tvalid && s_tready;

	// The output register frees up when empty or when its beat is taken.
	assign s_tready = !m_tvalid_q || m_tready;

	// Parse one byte and form the event it completes, if any.
	always_comb begin
		phase_d    = phase_q;
		event_d    = event_q;
		first_d    = first_q;
		acc_d      = acc_q;
		pend_d     = pend_q;
		finished_d = finished_q;
		vel_we     = 1'b0;
		do_emit    = 1'b0;
		do_finish  = 1'b0;
		res_vld    = 1'b0;
		res_end    = 1'b0;
		res_delta  = pend_q;
		res_status = '0;
		res_d1     = '0;
		res_d2     = '0;
		if (!finished_q) begin
			unique case (phase_q)
				PH_EVENT: begin
					event_d = b;
					if (b[6:4] == KIND_SCORE_END) begin
						do_finish = 1'b1;
					end else begin
						phase_d = PH_FIRST;
					end
				end
				PH_FIRST: begin
					first_d = b;
					case (kind)
						KIND_RELEASE: begin
							do_emit    = 1'b1;
							res_status = {ST_NOTE_ON, ch};
							res_d1     = b;
						end
						KIND_PLAY: begin
							if (b[7]) begin
								phase_d = PH_VELOCITY;
							end else begin
								do_emit    = 1'b1;
								res_status = {ST_NOTE_ON, ch};
								res_d1     = b;
								res_d2     = vel_q[ch];
							end
						end
						KIND_BEND: begin
							do_emit    = 1'b1;
							res_status = {ST_BEND, ch};
							res_d1     = {1'b0, b[0], 6'b0};
							res_d2     = {1'b0, b[7:1]};
						end
						KIND_SYSTEM: begin
							do_emit    = 1'b1;
							res_status = {ST_CTRL, ch};
							res_d1     = controller_of(b);
							res_d2     = (b == SYS_MONO_MODE) ? {4'b0, channel_count_q} : 8'd0;
						end
						KIND_CONTROLLER: begin
							phase_d = PH_VALUE;
						end
						default: begin
							do_finish = 1'b1;
						end
					endcase
				end
				PH_VELOCITY: begin
					vel_we     = 1'b1;
					do_emit    = 1'b1;
					res_status = {ST_NOTE_ON, ch};
					res_d1     = {1'b0, first_q[6:0]};
					res_d2     = b;
				end
				PH_VALUE: begin
					do_emit = 1'b1;
					if (first_q == CTRL_PROGRAM) begin
						res_status = {ST_PROGRAM, ch};
						res_d1     = b;
					end else begin
						res_status = {ST_CTRL, ch};
						res_d1     = ctl;
						res_d2     = (ctl == CTRL_VOLUME && b[7]) ? DATA_MAX : b;
					end
				end
				PH_DELAY: begin
					acc_d = {acc_q[24:0], b[6:0]};
					if (!b[7]) begin
						pend_d  = {acc_q[24:0], b[6:0]};
						phase_d = PH_EVENT;
					end
				end
				default: begin
					phase_d = PH_EVENT;
				end
			endcase
		end

		// A completed event takes the pending delay and may start a delay run.
		if (do_emit) begin
			res_vld = 1'b1;
			pend_d  = '0;
			if (event_q[7]) begin
				acc_d   = '0;
				phase_d = PH_DELAY;
			end else begin
				phase_d = PH_EVENT;
			end
		end

		// Score end or undefined kind: only a nonzero pending delay yields an end item.
		if (do_finish) begin
			finished_d = 1'b1;
			phase_d    = PH_EVENT;
			if (pend_q != 32'd0) begin
				res_vld = 1'b1;
				res_end = 1'b1;
				pend_d  = '0;
			end
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_EVENT;
			event_q    <= '0;
			first_q    <= '0;
			acc_q      <= '0;
			pend_q     <= '0;
			finished_q <= 1'b0;
		end else if (in_beat) begin
			phase_q    <= phase_d;
			event_q    <= event_d;
			first_q    <= first_d;
			acc_q      <= acc_d;
			pend_q     <= pend_d;
			finished_q <= finished_d;
		end
	end

	// Last velocity per MIDI channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				vel_q[i] <= VEL_RESET;
			end
		end else if (in_beat && vel_we) begin
			vel_q[ch] <= b;
		end
	end

	// Output register: loads on an accepted byte that completes an event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= in_beat && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && res_vld) begin
			m_tdata_q <= {res_d2, res_d1, res_status, res_delta};
			m_tlast_q <= res_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// Configuration register.
	assign reg_sel = (paddr[2] == REG_CHANNEL_COUNT);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			channel_count_q <= pwdata[3:0];
		end
	end

	assign prdata = reg_sel ? {28'b0, channel_count_q} : 32'd0;

	// An end item always carries a nonzero delay and a zero status.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[31:0] != 32'd0) && (m_tdata[39:32] == 8'd0))
	else $error("end item without pending delay or with nonzero status");

	// Once the score has ended, no new beat follows the last one taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		finished_q && m_tvalid && m_tready |=> !m_tvalid)
	else $error("result produced after score end");

	// A result only appears after an accepted input byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !in_beat |=> !m_tvalid)
	else $error("result appeared without an accepted byte");

endmodule
